FILE: src/task_scheduler_with_delays_core_defines.svh
// Assertion macros shared by the scheduler modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef TASK_SCHEDULER_WITH_DELAYS_CORE_DEFINES_SVH
`define TASK_SCHEDULER_WITH_DELAYS_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tsd_pkg.sv
package tsd_pkg;

    localparam int MAX_TASK_SLOTS = 8;
    localparam int SLOT_W         = 3;
    localparam int CNT_W          = 4;
    localparam int CMD_W          = 3;
    localparam int DELAY_W        = 32;
    localparam int SEM_W          = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_DELAY     = 3'd1,
        CMD_SEM_BLOCK = 3'd2,
        CMD_SEM_REL   = 3'd3,
        CMD_Q_BLOCK   = 3'd4,
        CMD_Q_WAKE    = 3'd5,
        CMD_YIELD     = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_BLOCKED = 2'd2
    } slot_state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic start;
        logic do_block;
        logic do_wake;
        logic do_demote;
        logic do_mod;
        logic set_idle;
        logic do_search;
        logic do_count;
        logic out_load;
    } ctl_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic n_zero;
        logic mod_ge;
        logic wake_hit;
        logic ready_hit;
        logic last;
    } stat_t;

endpackage

FILE: src/task_scheduler_with_delays_core.sv
// Round-robin task scheduler with timed delays, semaphore and queue waits.
// Input channel: in_valid/in_stall carry one command beat (cmd, delay_ticks,
// sem_id, queue_side). Output channel: out_valid/out_stall carry one result
// beat per command (running_task, idle_running, woken_valid, woken_task,
// status). cfg_we/cfg_wdata write the task count; write it only while idle.
// A sequencer visits one task slot per cycle through the single table port.
// The rescheduling search and the tick countdown each visit up to n slots,
// where n is the task count capped at the table size, and the wrap
// reduction of the search start subtracts n until the start is below n.
// The next command is taken once the result has moved to the output
// register, even if that beat is still waiting.
// Reset leaves every task ready, all delays and waits clear, no task running
// and the task count at one; the first rescheduling command starts at slot 0.
// While the receiver stalls, the result beat holds; a finished command then
// waits for the output register before the next beat is accepted.
module task_scheduler_with_delays_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tsd_pkg::CNT_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tsd_pkg::CMD_W-1:0]   cmd,
    input  logic [tsd_pkg::DELAY_W-1:0] delay_ticks,
    input  logic [tsd_pkg::SEM_W-1:0]   sem_id,
    input  logic                        queue_side,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tsd_pkg::SLOT_W-1:0]  running_task,
    output logic                        idle_running,
    output logic                        woken_valid,
    output logic [tsd_pkg::SLOT_W-1:0]  woken_task,
    output logic                        status
);

    tsd_pkg::ctl_t  ctl;
    tsd_pkg::stat_t stat;

    // The controller sequences each command; from the datapath it sees only status flags.
    tsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // The datapath holds the task table, scheduler state and result register.
    tsd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .delay_ticks  (delay_ticks),
        .sem_id       (sem_id),
        .queue_side   (queue_side),
        .ctl          (ctl),
        .stat         (stat),
        .running_task (running_task),
        .idle_running (idle_running),
        .woken_valid  (woken_valid),
        .woken_task   (woken_task),
        .status       (status)
    );

endmodule

FILE: src/tsd_datapath.sv
`include "task_scheduler_with_delays_core_defines.svh"

module tsd_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tsd_pkg::CNT_W-1:0]   cfg_wdata,
    input  logic [tsd_pkg::CMD_W-1:0]   cmd,
    input  logic [tsd_pkg::DELAY_W-1:0] delay_ticks,
    input  logic [tsd_pkg::SEM_W-1:0]   sem_id,
    input  logic                        queue_side,
    input  tsd_pkg::ctl_t               ctl,
    output tsd_pkg::stat_t              stat,
    output logic [tsd_pkg::SLOT_W-1:0]  running_task,
    output logic                        idle_running,
    output logic                        woken_valid,
    output logic [tsd_pkg::SLOT_W-1:0]  woken_task,
    output logic                        status
);

    localparam int NS = tsd_pkg::MAX_TASK_SLOTS;

    // Task table: every access but reset and the assertions uses the one slot pointer.
    tsd_pkg::slot_state_t              state_reg  [NS];
    logic [tsd_pkg::DELAY_W-1:0]       delay_reg  [NS];
    logic [tsd_pkg::SEM_W-1:0]         semw_reg   [NS];
    logic                              semf_reg   [NS];
    logic                              fullf_reg  [NS];
    logic                              emptyf_reg [NS];

    logic [tsd_pkg::CNT_W-1:0]   task_count_reg;
    logic [tsd_pkg::SLOT_W-1:0]  cur_reg, cur_next;
    logic                        on_idle_reg, on_idle_next;
    logic                        started_reg, started_next;
    logic [tsd_pkg::CNT_W-1:0]   ptr_reg, ptr_next;
    logic [tsd_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        woke_reg, woke_next;
    logic [tsd_pkg::SLOT_W-1:0]  woken_reg, woken_next;
    logic                        status_reg, status_next;

    logic [tsd_pkg::CMD_W-1:0]   cmd_reg;
    logic [tsd_pkg::DELAY_W-1:0] ticks_reg;
    logic [tsd_pkg::SEM_W-1:0]   sem_reg;
    logic                        side_reg;

    logic [tsd_pkg::SLOT_W-1:0]  out_running_reg;
    logic                        out_idle_reg;
    logic                        out_woke_reg;
    logic [tsd_pkg::SLOT_W-1:0]  out_woken_reg;
    logic                        out_status_reg;

    logic [tsd_pkg::SLOT_W-1:0]  slot;
    tsd_pkg::slot_state_t        slot_state, state_next;
    logic [tsd_pkg::DELAY_W-1:0] slot_delay, delay_next;
    logic [tsd_pkg::SEM_W-1:0]   slot_semw, semw_next;
    logic                        slot_semf, semf_next;
    logic                        slot_fullf, fullf_next;
    logic                        slot_emptyf, emptyf_next;

    logic [tsd_pkg::CNT_W-1:0]   n_slots;
    logic [tsd_pkg::CNT_W-1:0]   ptr_inc;
    logic [tsd_pkg::CNT_W-1:0]   ptr_adv;
    logic                        last;
    logic                        wake_hit;
    logic                        ready_hit;
    logic                        task_running;
    logic                        start_is_wake;
    logic [NS-1:0]               running_vec;

    assign slot        = ptr_reg[tsd_pkg::SLOT_W-1:0];
    assign slot_state  = state_reg[slot];
    assign slot_delay  = delay_reg[slot];
    assign slot_semw   = semw_reg[slot];
    assign slot_semf   = semf_reg[slot];
    assign slot_fullf  = fullf_reg[slot];
    assign slot_emptyf = emptyf_reg[slot];

    // Task counts above the table size saturate.
    assign n_slots = (task_count_reg > tsd_pkg::CNT_W'(NS)) ? tsd_pkg::CNT_W'(NS)
                                                             : task_count_reg;
    assign ptr_inc = ptr_reg + tsd_pkg::CNT_W'(1);
    assign ptr_adv = (ptr_inc == n_slots) ? '0 : ptr_inc;
    assign last    = (count_reg + tsd_pkg::CNT_W'(1)) == n_slots;

    assign wake_hit = (slot_state == tsd_pkg::ST_BLOCKED) &&
                      ((cmd_reg == tsd_pkg::CMD_SEM_REL) ? (slot_semf && slot_semw == sem_reg)
                                                         : (side_reg ? slot_emptyf
                                                                     : slot_fullf));
    assign ready_hit    = slot_state == tsd_pkg::ST_READY;
    assign task_running = (tsd_pkg::CNT_W'(cur_reg) < n_slots) &&
                          (slot_state == tsd_pkg::ST_RUNNING);
    assign start_is_wake = (cmd == tsd_pkg::CMD_SEM_REL) || (cmd == tsd_pkg::CMD_Q_WAKE);

    assign stat.n_zero    = n_slots == '0;
    assign stat.mod_ge    = ptr_reg >= n_slots;
    assign stat.wake_hit  = wake_hit;
    assign stat.ready_hit = ready_hit;
    assign stat.last      = last;

    always_comb
    begin
        state_next   = slot_state;
        delay_next   = slot_delay;
        semw_next    = slot_semw;
        semf_next    = slot_semf;
        fullf_next   = slot_fullf;
        emptyf_next  = slot_emptyf;
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        on_idle_next = on_idle_reg;
        started_next = started_reg;
        woke_next    = woke_reg;
        woken_next   = woken_reg;
        status_next  = status_reg;
        priority if (ctl.start)
        begin
            woke_next   = 1'b0;
            woken_next  = '0;
            status_next = start_is_wake && stat.n_zero;
            ptr_next    = start_is_wake ? '0 : tsd_pkg::CNT_W'(cur_reg);
            count_next  = '0;
        end
        else if (ctl.do_block)
        begin
            if (!task_running)
            begin
                status_next = 1'b1;
            end
            else if (cmd_reg == tsd_pkg::CMD_DELAY)
            begin
                // A zero delay leaves the task ready, so it behaves as a yield.
                if (ticks_reg != '0)
                begin
                    state_next = tsd_pkg::ST_BLOCKED;
                    delay_next = ticks_reg;
                end
            end
            else if (cmd_reg == tsd_pkg::CMD_SEM_BLOCK)
            begin
                state_next = tsd_pkg::ST_BLOCKED;
                semw_next  = sem_reg;
                semf_next  = 1'b1;
            end
            else
            begin
                state_next = tsd_pkg::ST_BLOCKED;
                if (side_reg)
                begin
                    fullf_next = 1'b1;
                end
                else
                begin
                    emptyf_next = 1'b1;
                end
            end
        end
        else if (ctl.do_wake)
        begin
            if (wake_hit)
            begin
                state_next = tsd_pkg::ST_READY;
                if (cmd_reg == tsd_pkg::CMD_SEM_REL)
                begin
                    semf_next = 1'b0;
                    semw_next = '0;
                end
                else if (side_reg)
                begin
                    emptyf_next = 1'b0;
                end
                else
                begin
                    fullf_next = 1'b0;
                end
                woke_next  = 1'b1;
                woken_next = slot;
                ptr_next   = tsd_pkg::CNT_W'(cur_reg);
            end
            else if (last)
            begin
                status_next = 1'b1;
                ptr_next    = tsd_pkg::CNT_W'(cur_reg);
            end
            else
            begin
                ptr_next   = ptr_adv;
                count_next = count_reg + tsd_pkg::CNT_W'(1);
            end
        end
        else if (ctl.do_demote)
        begin
            // Pointer is on the current slot, or slot 0 after a wake with no tasks.
            if (started_reg)
            begin
                if (slot_state == tsd_pkg::ST_RUNNING)
                begin
                    state_next = tsd_pkg::ST_READY;
                end
                ptr_next = tsd_pkg::CNT_W'(cur_reg) + tsd_pkg::CNT_W'(1);
            end
            else
            begin
                started_next = 1'b1;
                ptr_next     = '0;
            end
            count_next = '0;
        end
        else if (ctl.do_mod)
        begin
            ptr_next = ptr_reg - n_slots;
        end
        else if (ctl.set_idle)
        begin
            on_idle_next = 1'b1;
            ptr_next     = '0;
            count_next   = '0;
        end
        else if (ctl.do_search)
        begin
            if (ready_hit)
            begin
                state_next   = tsd_pkg::ST_RUNNING;
                cur_next     = slot;
                on_idle_next = 1'b0;
                ptr_next     = '0;
                count_next   = '0;
            end
            else if (last)
            begin
                on_idle_next = 1'b1;
                ptr_next     = '0;
                count_next   = '0;
            end
            else
            begin
                ptr_next   = ptr_adv;
                count_next = count_reg + tsd_pkg::CNT_W'(1);
            end
        end
        else if (ctl.do_count)
        begin
            if (slot_state == tsd_pkg::ST_BLOCKED && slot_delay != '0)
            begin
                delay_next = slot_delay - tsd_pkg::DELAY_W'(1);
                if (slot_delay == tsd_pkg::DELAY_W'(1))
                begin
                    state_next = tsd_pkg::ST_READY;
                    if (!woke_reg)
                    begin
                        woke_next  = 1'b1;
                        woken_next = slot;
                    end
                end
            end
            ptr_next   = ptr_inc;
            count_next = count_reg + tsd_pkg::CNT_W'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                state_reg[i]  <= tsd_pkg::ST_READY;
                delay_reg[i]  <= '0;
                semw_reg[i]   <= '0;
                semf_reg[i]   <= 1'b0;
                fullf_reg[i]  <= 1'b0;
                emptyf_reg[i] <= 1'b0;
            end
            task_count_reg <= tsd_pkg::CNT_W'(1);
            cur_reg        <= '0;
            on_idle_reg    <= 1'b0;
            started_reg    <= 1'b0;
            ptr_reg        <= '0;
            count_reg      <= '0;
            woke_reg       <= 1'b0;
            woken_reg      <= '0;
            status_reg     <= 1'b0;
        end
        else
        begin
            state_reg[slot]  <= state_next;
            delay_reg[slot]  <= delay_next;
            semw_reg[slot]   <= semw_next;
            semf_reg[slot]   <= semf_next;
            fullf_reg[slot]  <= fullf_next;
            emptyf_reg[slot] <= emptyf_next;
            if (cfg_we)
            begin
                task_count_reg <= cfg_wdata;
            end
            cur_reg     <= cur_next;
            on_idle_reg <= on_idle_next;
            started_reg <= started_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            woke_reg    <= woke_next;
            woken_reg   <= woken_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg   <= cmd;
            ticks_reg <= delay_ticks;
            sem_reg   <= sem_id;
            side_reg  <= queue_side;
        end
        if (ctl.out_load)
        begin
            out_running_reg <= (on_idle_reg || !started_reg) ? '0 : cur_reg;
            out_idle_reg    <= on_idle_reg;
            out_woke_reg    <= woke_reg;
            out_woken_reg   <= woke_reg ? woken_reg : '0;
            out_status_reg  <= status_reg;
        end
    end

    assign running_task = out_running_reg;
    assign idle_running = out_idle_reg;
    assign woken_valid  = out_woke_reg;
    assign woken_task   = out_woken_reg;
    assign status       = out_status_reg;

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            running_vec[i] = state_reg[i] == tsd_pkg::ST_RUNNING;
        end
    end

    `TSD_ASSERT_IMP(a_one_running, 1'b1, $countones(running_vec) <= 1, "more than one task running")
    `TSD_ASSERT_IMP(a_running_is_cur, |running_vec, running_vec[cur_reg], "running task not current")

endmodule

FILE: src/tsd_ctrl.sv
`include "task_scheduler_with_delays_core_defines.svh"

module tsd_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [tsd_pkg::CMD_W-1:0] cmd,
    output logic                      out_valid,
    input  logic                      out_stall,
    input  tsd_pkg::stat_t            stat,
    output tsd_pkg::ctl_t             ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLOCK,
        S_WAKE,
        S_DEMOTE,
        S_MOD,
        S_SEARCH,
        S_COUNT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   tick_reg, tick_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        tick_next  = tick_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.start = 1'b1;
                    tick_next = cmd == tsd_pkg::CMD_TICK;
                    priority if (cmd == tsd_pkg::CMD_TICK || cmd == tsd_pkg::CMD_YIELD)
                    begin
                        state_next = S_DEMOTE;
                    end
                    else if (cmd == tsd_pkg::CMD_DELAY || cmd == tsd_pkg::CMD_SEM_BLOCK ||
                             cmd == tsd_pkg::CMD_Q_BLOCK)
                    begin
                        state_next = S_BLOCK;
                    end
                    else if (cmd == tsd_pkg::CMD_SEM_REL || cmd == tsd_pkg::CMD_Q_WAKE)
                    begin
                        state_next = stat.n_zero ? S_DEMOTE : S_WAKE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_BLOCK:
            begin
                ctl.do_block = 1'b1;
                state_next   = S_DEMOTE;
            end
            S_WAKE:
            begin
                ctl.do_wake = 1'b1;
                if (stat.wake_hit || stat.last)
                begin
                    state_next = S_DEMOTE;
                end
            end
            S_DEMOTE:
            begin
                ctl.do_demote = 1'b1;
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                priority if (stat.n_zero)
                begin
                    ctl.set_idle = 1'b1;
                    state_next   = S_DONE;
                end
                else if (stat.mod_ge)
                begin
                    ctl.do_mod = 1'b1;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                ctl.do_search = 1'b1;
                if (stat.ready_hit || stat.last)
                begin
                    state_next = tick_reg ? S_COUNT : S_DONE;
                end
            end
            S_COUNT:
            begin
                ctl.do_count = 1'b1;
                if (stat.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TSD_ASSERT_IMP(a_search_has_tasks, state_reg == S_SEARCH, !stat.n_zero, "search with no tasks")
    `TSD_ASSERT_NXT(a_done_delivers, state_reg == S_DONE && !(out_valid_reg && out_stall), out_valid_reg && state_reg == S_IDLE, "result not presented")

endmodule
